/* rtl/pfsc_pkg.sv */
`default_nettype none
package pfsc_pkg;

  localparam int unsigned SrcEntries  = 1024;
  localparam int unsigned PairEntries = 1024;

  localparam int unsigned SrcIdxW  = (SrcEntries > 1) ? $clog2(SrcEntries) : 1;
  localparam int unsigned PairIdxW = (PairEntries > 1) ? $clog2(PairEntries) : 1;
  localparam int unsigned SrcCntW  = $clog2(SrcEntries + 1);
  localparam int unsigned PairCntW = $clog2(PairEntries + 1);
  localparam int unsigned ScanW    = (SrcCntW > PairCntW) ? SrcCntW : PairCntW;

  localparam logic [15:0] EthertypeIpv4 = 16'h0800;
  localparam logic [15:0] EthHdrBytes   = 16'd14;
  localparam logic [15:0] Ipv4MinBytes  = 16'd34;

  typedef enum logic [2:0] {
    ST_ABORT  = 3'd0,
    ST_PASS   = 3'd1,
    ST_DROP   = 3'd2,
    ST_STORED = 3'd3,
    ST_FULL   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CMD_ABORT = 2'd0,
    CMD_PASS  = 2'd1,
    CMD_FRAME = 2'd2,
    CMD_RULE  = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] src;
    logic [31:0] dst;
    logic        drop;
  } cmd_t;

endpackage
`default_nettype wire

/* rtl/pfsc_front.sv */
`default_nettype none
module pfsc_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push,
  output logic              full,
  input  wire logic         req_type_i,
  input  wire logic [15:0]  frame_length_i,
  input  wire logic [15:0]  ether_type_i,
  input  wire logic [31:0]  src_addr_i,
  input  wire logic [31:0]  dst_addr_i,
  input  wire logic         rule_drop_i,
  output logic              cmd_valid_o,
  output pfsc_pkg::cmd_t    cmd_o,
  input  wire logic         cmd_pop_i
);
  import pfsc_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cmd_new;
  logic       do_push, do_pop;

  always_comb begin
    cmd_new.src  = src_addr_i;
    cmd_new.dst  = dst_addr_i;
    cmd_new.drop = rule_drop_i;
    priority if (req_type_i) begin
      cmd_new.kind = CMD_RULE;
    end else if (frame_length_i < EthHdrBytes) begin
      cmd_new.kind = CMD_ABORT;
    end else if (ether_type_i != EthertypeIpv4) begin
      cmd_new.kind = CMD_PASS;
    end else if (frame_length_i < Ipv4MinBytes) begin
      cmd_new.kind = CMD_ABORT;
    end else begin
      cmd_new.kind = CMD_FRAME;
    end
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule
`default_nettype wire

/* rtl/pfsc_back.sv */
`default_nettype none
module pfsc_back (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         cmd_valid_i,
  input  wire pfsc_pkg::cmd_t cmd_i,
  output logic              cmd_pop_o,
  input  wire logic         pop,
  output logic              empty,
  output logic [2:0]        status_o,
  output logic [63:0]       source_count_o
);
  import pfsc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_PRD  = 3'd3;
  localparam logic [2:0] S_PCMP = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [ScanW-1:0]  idx_q, idx_d;
  cmd_t              cmd_q, cmd_d;
  logic [SrcCntW-1:0]  src_cnt_q, src_cnt_d;
  logic [PairCntW-1:0] pair_cnt_q, pair_cnt_d;
  logic [63:0]       count_q, count_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [63:0]       out_count_q, out_count_d;

  logic [31:0]       src_key_mem [SrcEntries];
  logic [63:0]       src_tally_mem [SrcEntries];
  logic [63:0]       pair_key_mem [PairEntries];
  logic              pair_flag_mem [PairEntries];

  logic [31:0]       src_rkey_q;
  logic [63:0]       src_rtally_q;
  logic [63:0]       pair_rkey_q;
  logic              pair_rflag_q;

  logic              src_we, pair_we, pair_key_we;
  logic [SrcIdxW-1:0]  src_waddr;
  logic [PairIdxW-1:0] pair_waddr;
  logic [63:0]       src_wtally;
  logic              pair_wflag;
  logic              out_set;
  logic [63:0]       pkey;
  logic              is_rule;

  assign pkey     = {cmd_q.src, cmd_q.dst};
  assign is_rule  = (cmd_q.kind == CMD_RULE);
  assign empty    = !out_valid_q;
  assign status_o = out_status_q;
  assign source_count_o = out_count_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    src_cnt_d    = src_cnt_q;
    pair_cnt_d   = pair_cnt_q;
    count_d      = count_q;
    out_set      = 1'b0;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    cmd_pop_o    = 1'b0;
    src_we       = 1'b0;
    src_waddr    = idx_q[SrcIdxW-1:0];
    src_wtally   = 64'd1;
    pair_we      = 1'b0;
    pair_key_we  = 1'b0;
    pair_waddr   = idx_q[PairIdxW-1:0];
    pair_wflag   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && !out_valid_q) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          count_d   = 64'd0;
          unique case (cmd_i.kind)
            CMD_ABORT: begin
              out_set      = 1'b1;
              out_status_d = ST_ABORT;
              out_count_d  = 64'd0;
            end
            CMD_PASS: begin
              out_set      = 1'b1;
              out_status_d = ST_PASS;
              out_count_d  = 64'd0;
            end
            CMD_FRAME: state_d = S_SRD;
            CMD_RULE:  state_d = S_PRD;
            default: ;
          endcase
        end
      end
      S_SRD: begin
        if (idx_q < ScanW'(src_cnt_q)) begin
          state_d = S_SCMP;
        end else begin
          if (src_cnt_q < SrcCntW'(SrcEntries)) begin
            src_we    = 1'b1;
            src_waddr = src_cnt_q[SrcIdxW-1:0];
            src_cnt_d = src_cnt_q + 1'b1;
            count_d   = 64'd1;
          end
          idx_d   = '0;
          state_d = S_PRD;
        end
      end
      S_SCMP: begin
        if (src_rkey_q == cmd_q.src) begin
          src_we     = 1'b1;
          src_wtally = src_rtally_q + 64'd1;
          count_d    = src_rtally_q + 64'd1;
          idx_d      = '0;
          state_d    = S_PRD;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_PRD: begin
        if (idx_q < ScanW'(pair_cnt_q)) begin
          state_d = S_PCMP;
        end else begin
          out_set     = 1'b1;
          out_count_d = count_q;
          state_d     = S_IDLE;
          if (pair_cnt_q < PairCntW'(PairEntries)) begin
            pair_we      = 1'b1;
            pair_key_we  = 1'b1;
            pair_waddr   = pair_cnt_q[PairIdxW-1:0];
            pair_wflag   = is_rule ? cmd_q.drop : 1'b0;
            pair_cnt_d   = pair_cnt_q + 1'b1;
            out_status_d = is_rule ? ST_STORED : ST_PASS;
          end else begin
            out_status_d = is_rule ? ST_FULL : ST_PASS;
          end
        end
      end
      S_PCMP: begin
        if (pair_rkey_q == pkey) begin
          out_set     = 1'b1;
          out_count_d = count_q;
          state_d     = S_IDLE;
          if (is_rule) begin
            pair_we      = 1'b1;
            pair_wflag   = cmd_q.drop;
            out_status_d = ST_STORED;
          end else begin
            out_status_d = pair_rflag_q ? ST_DROP : ST_PASS;
          end
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_PRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = out_set ? 1'b1 : ((pop && out_valid_q) ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      src_cnt_q   <= '0;
      pair_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      src_cnt_q   <= src_cnt_d;
      pair_cnt_q  <= pair_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    count_q      <= count_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  // source table
  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_key_mem[src_waddr]   <= cmd_q.src;
      src_tally_mem[src_waddr] <= src_wtally;
    end
    src_rkey_q   <= src_key_mem[idx_q[SrcIdxW-1:0]];
    src_rtally_q <= src_tally_mem[idx_q[SrcIdxW-1:0]];
  end

  // pair table
  always_ff @(posedge clk_i) begin
    if (pair_we) begin
      pair_flag_mem[pair_waddr] <= pair_wflag;
      if (pair_key_we) begin
        pair_key_mem[pair_waddr] <= pkey;
      end
    end
    pair_rkey_q  <= pair_key_mem[idx_q[PairIdxW-1:0]];
    pair_rflag_q <= pair_flag_mem[idx_q[PairIdxW-1:0]];
  end

endmodule
`default_nettype wire

/* rtl/ip_pair_filter_with_source_counts.sv */
// channel   handshake             payload
// request   push / full           req_type_i frame_length_i ether_type_i src_addr_i
//                                 dst_addr_i rule_drop_i
// result    empty / pop           status_o source_count_o
//
// aborted and non-ipv4 frames are answered from the back end's idle state, with no table scan
// ipv4 frames take a linear scan of the source table, then of the pair table;
// a scan reads and compares each entry up to and including a hit, or every entry in use on a miss;
// rule writes take the pair table scan only
// reset empties both tables at once through fill counts, no clearing pass
// a two-entry request queue lets requests arrive while the back end scans or the result waits
`default_nettype none
module ip_pair_filter_with_source_counts (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        req_type_i,
  input  wire logic [15:0] frame_length_i,
  input  wire logic [15:0] ether_type_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic        rule_drop_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [2:0]       status_o,
  output logic [63:0]      source_count_o
);
  import pfsc_pkg::*;

  logic cmd_valid, cmd_pop;
  cmd_t cmd;

  pfsc_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .req_type_i,
    .frame_length_i,
    .ether_type_i,
    .src_addr_i,
    .dst_addr_i,
    .rule_drop_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pfsc_back u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .pop,
    .empty,
    .status_o,
    .source_count_o
  );

`ifndef SYNTHESIS
  a_pop_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("queue popped while empty");
  a_pop_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> empty) else $error("request taken while result waits");
  a_abort_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (status_o == 3'(ST_ABORT) || status_o == 3'(ST_STORED)
     || status_o == 3'(ST_FULL))) |-> (source_count_o == 64'd0))
    else $error("count on result without tally");
`endif

endmodule
`default_nettype wire

/* verif/tb_ip_pair_filter_with_source_counts.sv */
`timescale 1ns / 1ps
module tb_ip_pair_filter_with_source_counts;
  import pfsc_pkg::*;

  typedef struct {
    logic        req_type;
    logic [15:0] frame_length;
    logic [15:0] ether_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic        rule_drop;
  } request_t;

  typedef struct {
    status_e     status;
    logic [63:0] source_count;
  } verdict_t;

  typedef struct {
    request_t req;
    logic     has_known;
    verdict_t known;
  } stim_row_t;

  localparam int unsigned NumRandom = 1425;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic req_type_i = 1'b0;
  logic [15:0] frame_length_i = '0;
  logic [15:0] ether_type_i = '0;
  logic [31:0] src_addr_i = '0;
  logic [31:0] dst_addr_i = '0;
  logic rule_drop_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] status_o;
  logic [63:0] source_count_o;

  ip_pair_filter_with_source_counts dut (
    .clk_i, .rst_ni, .push, .full, .req_type_i, .frame_length_i, .ether_type_i,
    .src_addr_i, .dst_addr_i, .rule_drop_i, .empty, .pop, .status_o, .source_count_o
  );

  // shadow tables
  bit          src_used [SrcEntries];
  logic [31:0] src_key_tbl [SrcEntries];
  logic [63:0] src_tally_tbl [SrcEntries];
  bit          pair_used [PairEntries];
  logic [63:0] pair_key_tbl [PairEntries];
  bit          pair_drop_tbl [PairEntries];

  verdict_t pending_verdicts[$];
  int unsigned mismatches = 0;
  int unsigned verdicts_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned fulls_seen = 0;
  bit sending_done = 1'b0;
  bit hold_pop = 1'b0;
  int unsigned src_pool[$];

  function automatic verdict_t classify_request(request_t r);
    verdict_t v;
    logic [63:0] pk;
    int hit, free_slot;
    v.source_count = '0;
    pk = {r.src_addr, r.dst_addr};
    if (r.req_type) begin
      hit = -1; free_slot = -1;
      for (int i = 0; i < PairEntries; i++) begin
        if (pair_used[i]) begin
          if (pair_key_tbl[i] == pk && hit < 0) hit = i;
        end else if (free_slot < 0) free_slot = i;
      end
      if (hit >= 0) begin
        pair_drop_tbl[hit] = r.rule_drop;
        v.status = ST_STORED;
      end else if (free_slot >= 0) begin
        pair_used[free_slot] = 1'b1;
        pair_key_tbl[free_slot] = pk;
        pair_drop_tbl[free_slot] = r.rule_drop;
        v.status = ST_STORED;
      end else begin
        v.status = ST_FULL;
      end
    end else if (r.frame_length < EthHdrBytes) begin
      v.status = ST_ABORT;
    end else if (r.ether_type != EthertypeIpv4) begin
      v.status = ST_PASS;
    end else if (r.frame_length < Ipv4MinBytes) begin
      v.status = ST_ABORT;
    end else begin
      hit = -1; free_slot = -1;
      for (int i = 0; i < SrcEntries; i++) begin
        if (src_used[i]) begin
          if (src_key_tbl[i] == r.src_addr && hit < 0) hit = i;
        end else if (free_slot < 0) free_slot = i;
      end
      if (hit >= 0) begin
        src_tally_tbl[hit] = src_tally_tbl[hit] + 64'd1;
        v.source_count = src_tally_tbl[hit];
      end else if (free_slot >= 0) begin
        src_used[free_slot] = 1'b1;
        src_key_tbl[free_slot] = r.src_addr;
        src_tally_tbl[free_slot] = 64'd1;
        v.source_count = 64'd1;
      end
      hit = -1; free_slot = -1;
      for (int i = 0; i < PairEntries; i++) begin
        if (pair_used[i]) begin
          if (pair_key_tbl[i] == pk && hit < 0) hit = i;
        end else if (free_slot < 0) free_slot = i;
      end
      if (hit >= 0 && pair_drop_tbl[hit]) begin
        v.status = ST_DROP;
      end else begin
        if (hit < 0 && free_slot >= 0) begin
          pair_used[free_slot] = 1'b1;
          pair_key_tbl[free_slot] = pk;
          pair_drop_tbl[free_slot] = 1'b0;
        end
        v.status = ST_PASS;
      end
    end
    return v;
  endfunction

  function automatic request_t make_req(logic t, logic [15:0] len, logic [15:0] et,
                                        logic [31:0] s, logic [31:0] d, logic rd);
    request_t r;
    r.req_type = t; r.frame_length = len; r.ether_type = et;
    r.src_addr = s; r.dst_addr = d; r.rule_drop = rd;
    return r;
  endfunction

  function automatic request_t random_request();
    request_t r;
    int unsigned pick;
    r.req_type = ($urandom_range(0, 4) == 0);
    r.rule_drop = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 9);
    if (pick == 0) r.frame_length = 16'($urandom_range(0, 13));
    else if (pick == 1) r.frame_length = 16'($urandom_range(14, 33));
    else if (pick == 2) r.frame_length = 16'($urandom);
    else r.frame_length = 16'($urandom_range(34, 1518));
    r.ether_type = ($urandom_range(0, 5) == 0) ? 16'($urandom) : EthertypeIpv4;
    // small address pool so counts and pairs repeat
    if ($urandom_range(0, 7) == 0) begin
      r.src_addr = $urandom;
      r.dst_addr = $urandom;
    end else begin
      r.src_addr = src_pool[$urandom_range(0, src_pool.size() - 1)];
      r.dst_addr = src_pool[$urandom_range(0, src_pool.size() - 1)] ^ 32'h0000_00ff;
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push <= 1'b1;
    req_type_i <= r.req_type;
    frame_length_i <= r.frame_length;
    ether_type_i <= r.ether_type;
    src_addr_i <= r.src_addr;
    dst_addr_i <= r.dst_addr;
    rule_drop_i <= r.rule_drop;
    do @(posedge clk_i); while (full);
    @(negedge clk_i);
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver
  initial begin
    int unsigned wait_cycles;
    verdict_t want;
    @(negedge clk_i);
    forever begin
      wait_cycles = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 12);
      if (hold_pop || wait_cycles != 0) begin
        pop <= 1'b0;
        while (hold_pop) @(negedge clk_i);
        repeat (wait_cycles) @(negedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected verdict status=%0d count=%0d",
                                       status_o, source_count_o);
      end else begin
        want = pending_verdicts.pop_front();
        if (status_o !== want.status || source_count_o !== want.source_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: status exp %0d got %0d, count exp %0d got %0d",
                     want.status, status_o, want.source_count, source_count_o);
        end
        if (want.status == ST_DROP) drops_seen++;
        if (want.status == ST_FULL) fulls_seen++;
      end
      @(negedge clk_i);
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    verdict_t v;
    int unsigned timeout;
    for (int i = 0; i < 40; i++) src_pool.push_back($urandom);
    rows = '{
      '{make_req(1'b0, 16'd0, EthertypeIpv4, 32'h0, 32'h0, 1'b0), 1'b1,
        '{ST_ABORT, 64'd0}},
      '{make_req(1'b0, 16'd13, EthertypeIpv4, 32'hffff_ffff, 32'h1, 1'b1), 1'b1,
        '{ST_ABORT, 64'd0}},
      '{make_req(1'b0, 16'd14, 16'h86dd, 32'h1, 32'h2, 1'b0), 1'b1, '{ST_PASS, 64'd0}},
      '{make_req(1'b0, 16'hffff, 16'hffff, 32'h1, 32'h2, 1'b0), 1'b1, '{ST_PASS, 64'd0}},
      '{make_req(1'b0, 16'd33, EthertypeIpv4, 32'h1, 32'h2, 1'b0), 1'b1,
        '{ST_ABORT, 64'd0}},
      '{make_req(1'b0, 16'd34, EthertypeIpv4, 32'h0, 32'h0, 1'b0), 1'b1,
        '{ST_PASS, 64'd1}},
      '{make_req(1'b0, 16'hffff, EthertypeIpv4, 32'h0, 32'h0, 1'b0), 1'b1,
        '{ST_PASS, 64'd2}},
      '{make_req(1'b1, 16'd0, 16'h0, 32'h0, 32'h0, 1'b1), 1'b1, '{ST_STORED, 64'd0}},
      '{make_req(1'b0, 16'd60, EthertypeIpv4, 32'h0, 32'h0, 1'b0), 1'b1,
        '{ST_DROP, 64'd3}},
      '{make_req(1'b1, 16'hffff, 16'hffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1), 1'b1,
        '{ST_STORED, 64'd0}},
      '{make_req(1'b0, 16'd64, EthertypeIpv4, 32'hffff_ffff, 32'hffff_ffff, 1'b1), 1'b1,
        '{ST_DROP, 64'd1}},
      '{make_req(1'b1, 16'd0, 16'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b0), 1'b1,
        '{ST_STORED, 64'd0}},
      '{make_req(1'b0, 16'd64, EthertypeIpv4, 32'hffff_ffff, 32'hffff_ffff, 1'b0), 1'b1,
        '{ST_PASS, 64'd2}},
      '{make_req(1'b0, 16'd100, EthertypeIpv4, 32'haaaa_5555, 32'h5555_aaaa, 1'b0), 1'b0,
        '{ST_PASS, 64'd0}},
      '{make_req(1'b1, 16'd5, 16'h0800, 32'haaaa_5555, 32'h5555_aaaa, 1'b1), 1'b0,
        '{ST_PASS, 64'd0}},
      '{make_req(1'b0, 16'd100, EthertypeIpv4, 32'haaaa_5555, 32'h5555_aaaa, 1'b0), 1'b0,
        '{ST_PASS, 64'd0}},
      '{make_req(1'b0, 16'd100, 16'h0801, 32'haaaa_5555, 32'h5555_aaaa, 1'b0), 1'b0,
        '{ST_PASS, 64'd0}}
    };
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i]) begin
      row = rows[i];
      v = classify_request(row.req);
      if (row.has_known && (v.status != row.known.status
          || v.source_count != row.known.source_count)) begin
        mismatches++;
        $display("directed row %0d: table value disagrees with prediction", i);
      end
      pending_verdicts.push_back(v);
      send_request(row.req);
    end
    for (int n = 0; n < NumRandom; n++) begin
      request_t r;
      if (n == 300) begin
        hold_pop = 1'b1;
        fork begin
          repeat (400) @(negedge clk_i);
          hold_pop = 1'b0;
        end join_none
      end
      r = random_request();
      pending_verdicts.push_back(classify_request(r));
      send_request(r);
    end
    push <= 1'b0;
    timeout = 0;
    while (pending_verdicts.size() != 0 && timeout < 200000) begin
      @(posedge clk_i);
      timeout++;
    end
    repeat (50) @(posedge clk_i);
    $display("%0d requests checked (%0d drops, %0d rule-full), directed edges plus",
             verdicts_seen, drops_seen, fulls_seen);
    $display("random mix of frames and rule writes with a long result back-pressure");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* ip_pair_filter_with_source_counts.f */
rtl/pfsc_pkg.sv
rtl/pfsc_front.sv
rtl/pfsc_back.sv
rtl/ip_pair_filter_with_source_counts.sv
verif/tb_ip_pair_filter_with_source_counts.sv
